/* rtl/olid_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_pkg: shared types for the ordered list block
// Holds the request and response payloads, the operation and status codes,
// and the control and result records that travel along the row of cells.
// ----------------------------------------------------------------------------
package olid_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int LEN_W  = 9;
  localparam int OUT_W  = 5;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]        op;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] element;
    logic [OUT_W-1:0]  found_position;
    logic [OUT_W-1:0]  count;
  } rsp_t;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic              clr;
    logic [LEN_W-1:0]  pos;
    logic [LEN_W-1:0]  count;
    logic [DATA_W-1:0] value;
  } ctrl_t;

  typedef struct packed {
    logic              found;
    logic [OUT_W-1:0]  found_pos;
    logic [DATA_W-1:0] elem;
  } acc_t;

endpackage

/* rtl/olid_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_req_if: request channel
// Valid/ready channel that carries one list operation per request.
// ----------------------------------------------------------------------------
interface olid_req_if;
  import olid_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/olid_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_rsp_if: response channel
// Valid/ready channel that carries one result per request.
// ----------------------------------------------------------------------------
interface olid_rsp_if;
  import olid_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/olid_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_cell: one slot of the list
// Holds one entry, takes its neighbor's entry on insert or delete, and adds
// its read and first-match result to the record passed along the row.
// ----------------------------------------------------------------------------
module olid_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  olid_pkg::ctrl_t           ctrl_i,
  input  logic [olid_pkg::DATA_W-1:0] left_i,
  input  logic [olid_pkg::DATA_W-1:0] right_i,
  output logic [olid_pkg::DATA_W-1:0] data_o,
  input  olid_pkg::acc_t            acc_i,
  output olid_pkg::acc_t            acc_o
);
  import olid_pkg::*;

  localparam logic [LEN_W-1:0] SLOT = LEN_W'(IDX + 1);

  logic [DATA_W-1:0] data_q, data_d;
  logic              hit;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.clr) begin
      data_d = '0;
    end else if (ctrl_i.ins) begin
      if (SLOT == ctrl_i.pos) begin
        data_d = ctrl_i.value;
      end else if (SLOT > ctrl_i.pos) begin
        data_d = left_i;
      end
    end else if (ctrl_i.del) begin
      if (SLOT >= ctrl_i.pos) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign hit = (data_q == ctrl_i.value) && (SLOT <= ctrl_i.count);

  always_comb begin
    acc_o       = acc_i;
    acc_o.found = acc_i.found | hit;
    if (hit && !acc_i.found) begin
      acc_o.found_pos = SLOT[OUT_W-1:0];
    end
    if (SLOT == ctrl_i.pos) begin
      acc_o.elem = acc_i.elem | data_q;
    end
  end

  assign data_o = data_q;

endmodule

/* rtl/ordered_list_insert_delete_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_top: fixed-capacity ordered list
// Packed list of signed words with insert, delete, get, locate and clear,
// held in a row of cells that shift together.
//
//   channel | dir | payload
//   req_i   | in  | op, position, value
//   rsp_o   | out | status, element, found_position, count
//
// One request per cycle while the response side keeps up: the cell row
// shifts and compares, and the result sits in an output register the cycle after.
// A new request is taken while the held result is being taken.
// Reset clears every entry and the count; no clearing pass follows.
// A stalled result holds its register and blocks only further requests.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_top #(
  parameter int CAPACITY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  olid_req_if.sink   req_i,
  olid_rsp_if.source rsp_o
);
  import olid_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]  count_q, count_d;
  logic              rsp_valid_q;
  rsp_t              rsp_q, rsp_d;
  logic              fire;
  logic [LEN_W-1:0]  count_ext, pos_ext, count_next_ext;
  logic              ins_ok, del_ok, pos_ok, ins_pos_ok;
  ctrl_t             ctrl;
  logic [DATA_W-1:0] ent [CAPACITY];
  acc_t              acc [CAPACITY+1];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;

  assign count_ext  = LEN_W'(count_q);
  assign pos_ext    = LEN_W'(req_i.data.position);
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= count_ext + LEN_W'(1));
  assign pos_ok     = (pos_ext != '0) && (pos_ext <= count_ext);
  assign ins_ok     = ins_pos_ok && (count_ext < LEN_W'(CAPACITY));
  assign del_ok     = pos_ok;

  always_comb begin
    ctrl       = '0;
    ctrl.ins   = fire && (req_i.data.op == OP_INSERT) && ins_ok;
    ctrl.del   = fire && (req_i.data.op == OP_DELETE) && del_ok;
    ctrl.clr   = fire && (req_i.data.op == OP_CLEAR);
    ctrl.pos   = pos_ext;
    ctrl.count = count_ext;
    ctrl.value = req_i.data.value;
  end

  assign acc[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = ent[i+1];
    end
    olid_cell #(.IDX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .data_o  (ent[i]),
      .acc_i   (acc[i]),
      .acc_o   (acc[i+1])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.clr) begin
      count_d = '0;
    end else if (ctrl.ins) begin
      count_d = CNT_W'(count_ext + LEN_W'(1));
    end else if (ctrl.del) begin
      count_d = CNT_W'(count_ext - LEN_W'(1));
    end
  end

  assign count_next_ext = LEN_W'(count_d);

  always_comb begin
    rsp_d       = '0;
    rsp_d.count = count_next_ext[OUT_W-1:0];
    case (req_i.data.op)
      OP_INSERT: begin
        if (!ins_pos_ok) begin
          rsp_d.status = ST_BADPOS;
        end else if (!ins_ok) begin
          rsp_d.status = ST_FULL;
        end
      end
      OP_DELETE, OP_GET: begin
        if (pos_ok) begin
          rsp_d.element = acc[CAPACITY].elem;
        end else begin
          rsp_d.status = ST_BADPOS;
        end
      end
      OP_LOCATE: begin
        if (acc[CAPACITY].found) begin
          rsp_d.found_position = acc[CAPACITY].found_pos;
        end else begin
          rsp_d.status = ST_NOTFOUND;
        end
      end
      default: begin
        rsp_d.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

endmodule
